// File: rtl/apsp_pkg.sv
// Shared constants, item kinds and the saturating distance add for the
// all-pairs shortest path block. No dependencies.
package apsp_pkg;

    localparam int          MAX_NODES_DEF  = 64;
    localparam int          DIST_W         = 32;
    localparam logic [31:0] DIST_INF       = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_ZERO      = 32'h0000_0000;
    localparam logic [6:0]  NODE_COUNT_RST = 7'd64;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Infinity absorbs; any sum reaching all ones saturates to infinity.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if ((a == DIST_INF) || (b == DIST_INF) || (s >= {1'b0, DIST_INF}))
        begin
            sat_add = DIST_INF;
        end
        else
        begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

// File: rtl/apsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module apsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/all_pairs_shortest_path.sv
// One item in flight at a time. The relaxation is bound by the single read
// port of the distance RAM: it spends a read of k-j, a read of i-j and a
// write back on each (k, i, j) triple, plus a fetch of i-k per (k, i) row.
// Reset clears control state, sets node_count to 64 and then sweeps the RAM to
// infinity with in_ready low; node_count writes still land.
module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        node_count_we,
    input  logic [6:0]  node_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [5:0]  row_node,
    input  logic [5:0]  col_node,
    input  logic [31:0] edge_distance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] path_distance,
    output logic        reachable
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = NW + 1;
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_FIN,
        S_SY_A,
        S_SY_B,
        S_SY_W,
        S_SY_W2,
        S_DIAG,
        S_FW_IK,
        S_FW_KJ,
        S_FW_IJ,
        S_FW_WR
    } state_t;

    function automatic logic [AW-1:0] ent_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
        ent_addr = AW'(int'(r) * MAX_NODES + int'(c));
    endfunction

    state_t          state_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic            clr_emit_reg;
    logic [NW-1:0]   i_reg;
    logic [NW-1:0]   j_reg;
    logic [NW-1:0]   k_reg;
    logic [CW-1:0]   n_reg;
    logic [31:0]     a_reg;
    logic [31:0]     ik_reg;
    logic [31:0]     via_reg;
    logic            in_range_reg;
    logic [31:0]     res_dist_reg;
    logic            res_reach_reg;
    logic            out_valid_reg;
    logic [31:0]     out_dist_reg;
    logic            out_reach_reg;
    logic [6:0]      node_count_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic            accept;
    logic            in_range;
    logic [AW-1:0]   in_addr;
    logic [CW-1:0]   n_use;
    logic [CW-1:0]   i1;
    logic [CW-1:0]   i2;
    logic [CW-1:0]   j1;
    logic [CW-1:0]   k1;
    logic            sy_fix;
    logic            fw_upd;
    logic            out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (int'(row_node) < MAX_NODES) && (int'(col_node) < MAX_NODES);
    assign in_addr  = ent_addr(NW'(row_node), NW'(col_node));
    assign n_use    = (int'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign i1       = {1'b0, i_reg} + CW'(1);
    assign i2       = {1'b0, i_reg} + CW'(2);
    assign j1       = {1'b0, j_reg} + CW'(1);
    assign k1       = {1'b0, k_reg} + CW'(1);
    assign sy_fix   = (a_reg == DIST_INF) || (ram_rdata == DIST_INF);
    assign fw_upd   = (ram_rdata > via_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = DIST_INF;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            S_IDLE:
            begin
                ram_waddr = in_addr;
                ram_raddr = in_addr;
                ram_wdata = edge_distance;
                ram_we    = accept && in_range && (kind == KIND_LOAD);
                ram_re    = accept && in_range && (kind == KIND_READ);
            end
            S_SY_A:
            begin
                ram_re    = 1'b1;
                ram_raddr = ent_addr(i_reg, j_reg);
            end
            S_SY_B:
            begin
                ram_re    = 1'b1;
                ram_raddr = ent_addr(j_reg, i_reg);
            end
            S_SY_W:
            begin
                ram_we    = sy_fix;
                ram_waddr = ent_addr(i_reg, j_reg);
            end
            S_SY_W2:
            begin
                ram_we    = 1'b1;
                ram_waddr = ent_addr(j_reg, i_reg);
            end
            S_DIAG:
            begin
                ram_we    = 1'b1;
                ram_waddr = ent_addr(i_reg, i_reg);
                ram_wdata = DIST_ZERO;
            end
            S_FW_IK:
            begin
                ram_re    = 1'b1;
                ram_raddr = ent_addr(i_reg, k_reg);
            end
            S_FW_KJ:
            begin
                ram_re    = 1'b1;
                ram_raddr = ent_addr(k_reg, j_reg);
            end
            S_FW_IJ:
            begin
                ram_re    = 1'b1;
                ram_raddr = ent_addr(i_reg, j_reg);
            end
            S_FW_WR:
            begin
                ram_we    = fw_upd;
                ram_waddr = ent_addr(i_reg, j_reg);
                ram_wdata = via_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    apsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_addr_reg   <= '0;
            clr_emit_reg   <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            a_reg          <= '0;
            ik_reg         <= '0;
            via_reg        <= '0;
            in_range_reg   <= 1'b0;
            res_dist_reg   <= '0;
            res_reach_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_dist_reg   <= '0;
            out_reach_reg  <= 1'b0;
            node_count_reg <= NODE_COUNT_RST;
        end
        else
        begin
            if (node_count_we)
            begin
                node_count_reg <= node_count;
            end

            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= clr_emit_reg ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_dist_reg  <= DIST_ZERO;
                        res_reach_reg <= 1'b0;
                        in_range_reg  <= in_range;
                        case (kind)
                            KIND_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                clr_emit_reg <= 1'b1;
                                state_reg    <= S_CLR;
                            end
                            KIND_LOAD:
                            begin
                                state_reg <= S_FIN;
                            end
                            KIND_SOLVE:
                            begin
                                n_reg <= n_use;
                                i_reg <= '0;
                                j_reg <= NW'(1);
                                if (n_use >= CW'(2))
                                begin
                                    state_reg <= S_SY_A;
                                end
                                else if (n_use == CW'(1))
                                begin
                                    state_reg <= S_DIAG;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                            KIND_READ:
                            begin
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    if (in_range_reg)
                    begin
                        res_dist_reg  <= ram_rdata;
                        res_reach_reg <= (ram_rdata != DIST_INF);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dist_reg  <= res_dist_reg;
                        out_reach_reg <= res_reach_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                S_SY_A:
                begin
                    state_reg <= S_SY_B;
                end
                S_SY_B:
                begin
                    a_reg     <= ram_rdata;
                    state_reg <= S_SY_W;
                end
                S_SY_W, S_SY_W2:
                begin
                    if ((state_reg == S_SY_W) && sy_fix)
                    begin
                        state_reg <= S_SY_W2;
                    end
                    else if (j1 < n_reg)
                    begin
                        j_reg     <= j1[NW-1:0];
                        state_reg <= S_SY_A;
                    end
                    else if (i2 < n_reg)
                    begin
                        i_reg     <= i1[NW-1:0];
                        j_reg     <= i2[NW-1:0];
                        state_reg <= S_SY_A;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_DIAG;
                    end
                end
                S_DIAG:
                begin
                    if (i1 < n_reg)
                    begin
                        i_reg <= i1[NW-1:0];
                    end
                    else
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_FW_IK;
                    end
                end
                S_FW_IK:
                begin
                    state_reg <= S_FW_KJ;
                end
                S_FW_KJ:
                begin
                    // first column of a row: data is d[i][k]
                    if (j_reg == '0)
                    begin
                        ik_reg <= ram_rdata;
                    end
                    state_reg <= S_FW_IJ;
                end
                S_FW_IJ:
                begin
                    via_reg   <= sat_add(ik_reg, ram_rdata);
                    state_reg <= S_FW_WR;
                end
                S_FW_WR:
                begin
                    if (j1 < n_reg)
                    begin
                        j_reg     <= j1[NW-1:0];
                        state_reg <= S_FW_KJ;
                    end
                    else
                    begin
                        j_reg <= '0;
                        if (i1 < n_reg)
                        begin
                            i_reg     <= i1[NW-1:0];
                            state_reg <= S_FW_IK;
                        end
                        else
                        begin
                            i_reg <= '0;
                            if (k1 < n_reg)
                            begin
                                k_reg     <= k1[NW-1:0];
                                state_reg <= S_FW_IK;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign path_distance = out_dist_reg;
    assign reachable     = out_reach_reg;

    // no read and write of one entry in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide on one entry");

    // relaxation indices stay inside the active node range
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FW_IK) || (state_reg == S_FW_KJ) || (state_reg == S_FW_IJ)
         || (state_reg == S_FW_WR))
        |-> (({1'b0, i_reg} < n_reg) && ({1'b0, j_reg} < n_reg) && ({1'b0, k_reg} < n_reg)))
        else $error("relaxation index out of range");

    // pair sweep only visits the upper triangle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SY_A) |-> ((i_reg < j_reg) && ({1'b0, j_reg} < n_reg)))
        else $error("pair sweep index out of range");

    // a finite flag always goes with a finite distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reach_reg) |-> (out_dist_reg != DIST_INF))
        else $error("reachable set on infinite distance");

    // one item at a time: a transfer in closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input reopened straight after a transfer");

endmodule
